### hw/rtl/iapm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iapm_pkg;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int MODE_W = 7;
	localparam int PLEN_W = 6;
	localparam int IDX_W  = 4;
	localparam int CFG_W  = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic CFG_RESERVED_PORT_LIMIT = 1'b0;
	localparam logic CFG_DEFAULT_MODE        = 1'b1;

	localparam logic [PORT_W-1:0] RESERVED_PORT_LIMIT_RESET = 16'd1024;
	localparam logic [MODE_W-1:0] DEFAULT_MODE_RESET        = 7'd19;

	localparam logic [MODE_W-1:0] MODE_HOST        = 7'h02;
	localparam logic [MODE_W-1:0] MODE_HOST_SECURE = 7'h10;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  index;
		logic              enable;
		logic [ADDR_W-1:0] network;
		logic [ADDR_W-1:0] mask;
		logic [MODE_W-1:0] mode;
	} iapm_wr_t;

	typedef struct packed {
		logic              active;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [MODE_W-1:0] mode;
		logic              matched;
		logic              any_valid;
	} iapm_token_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              matched;
	} iapm_result_t;

	function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [PLEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= PLEN_W'(ADDR_W)) begin
			m = '1;
		end else begin
			m = {ADDR_W{1'b1}} << (PLEN_W'(ADDR_W) - len);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/iapm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module iapm_cell #(
	parameter int CELL_ID = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  iapm_pkg::iapm_wr_t    wr,
	input  iapm_pkg::iapm_token_t tok_in,
	output iapm_pkg::iapm_token_t tok_out
);
	import iapm_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] network_q;
	logic [ADDR_W-1:0] mask_q;
	logic [MODE_W-1:0] mode_q;
	iapm_token_t       tok_q;
	iapm_token_t       tok_next;
	logic              hit;

	assign hit = wr.en && (int'(wr.index) == CELL_ID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit) begin
			valid_q <= wr.enable;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			if (wr.enable) begin
				mask_q    <= wr.mask;
				network_q <= wr.network & wr.mask;
				mode_q    <= wr.mode;
			end else begin
				mask_q    <= '0;
				network_q <= '0;
				mode_q    <= '0;
			end
		end
	end

	always_comb begin
		tok_next = tok_in;
		if (valid_q) begin
			tok_next.any_valid = 1'b1;
			if ((tok_in.addr & mask_q) == network_q) begin
				tok_next.mode    = mode_q;
				tok_next.matched = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

### hw/rtl/iapm_resolve.sv
`timescale 1ns / 1ps
`default_nettype none
module iapm_resolve (
	input  iapm_pkg::iapm_token_t             tok,
	input  wire [iapm_pkg::PORT_W-1:0]        reserved_port_limit,
	input  wire [iapm_pkg::MODE_W-1:0]        default_mode,
	output iapm_pkg::iapm_result_t            res
);
	import iapm_pkg::*;

	logic [MODE_W-1:0] mode;
	logic [MODE_W-1:0] host_bits;

	assign host_bits = MODE_HOST | MODE_HOST_SECURE;

	always_comb begin
		mode = tok.mode;
		if ((mode & MODE_HOST_SECURE) != '0) begin
			mode = mode | MODE_HOST;
			if (tok.port >= reserved_port_limit) begin
				if ((mode & ~host_bits) != '0) begin
					mode = mode & ~host_bits;
				end else begin
					mode = '0;
				end
			end
		end
		if (!tok.any_valid) begin
			res.mode    = default_mode;
			res.matched = 1'b0;
		end else begin
			res.mode    = mode;
			res.matched = tok.matched;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/ipv4_acl_prefix_match.sv
`timescale 1ns / 1ps
`default_nettype none
// For a rule write, done pulses in the cycle after start and busy never rises.
// A client check passes through a chain of RULE_SLOTS cells, one cell per cycle, and done
// is registered from the last cell's output token; busy stays high until done pulses, so one check
// is in flight at a time. Each word is valid on the outputs while done is high, for a single
// cycle, and the receiver cannot stall it. The valid bit of every slot clears at reset, so
// no clearing pass is needed and the block is ready right after reset.
module ipv4_acl_prefix_match #(
	parameter int RULE_SLOTS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          operation,
	input  wire [iapm_pkg::IDX_W-1:0]    rule_index,
	input  wire                          rule_enable,
	input  wire [iapm_pkg::ADDR_W-1:0]   rule_network,
	input  wire [iapm_pkg::PLEN_W-1:0]   prefix_length,
	input  wire [iapm_pkg::MODE_W-1:0]   rule_mode,
	input  wire [iapm_pkg::ADDR_W-1:0]   client_address,
	input  wire [iapm_pkg::PORT_W-1:0]   client_port,
	output logic                         done,
	output logic [iapm_pkg::MODE_W-1:0]  access_mode,
	output logic                         rule_matched,
	output logic                         write_done,
	input  wire                          cfg_write,
	input  wire                          cfg_index,
	input  wire [iapm_pkg::CFG_W-1:0]    cfg_data
);
	import iapm_pkg::*;

	logic              accept;
	logic              busy_q;
	logic              done_q;
	logic [MODE_W-1:0] access_mode_q;
	logic              rule_matched_q;
	logic              write_done_q;
	logic [PORT_W-1:0] reserved_port_limit_q;
	logic [MODE_W-1:0] default_mode_q;
	iapm_wr_t          wr;
	iapm_token_t       chain [0:RULE_SLOTS];
	iapm_result_t      res;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_port_limit_q <= RESERVED_PORT_LIMIT_RESET;
			default_mode_q        <= DEFAULT_MODE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RESERVED_PORT_LIMIT: reserved_port_limit_q <= cfg_data[PORT_W-1:0];
				CFG_DEFAULT_MODE:        default_mode_q        <= cfg_data[MODE_W-1:0];
				default:                 ;
			endcase
		end
	end

	always_comb begin
		wr.en      = accept && (operation == OP_WRITE);
		wr.index   = rule_index;
		wr.enable  = rule_enable;
		wr.network = rule_network;
		wr.mask    = prefix_to_mask(prefix_length);
		wr.mode    = rule_mode;
	end

	always_comb begin
		chain[0].active    = accept && (operation == OP_CHECK);
		chain[0].addr      = client_address;
		chain[0].port      = client_port;
		chain[0].mode      = '0;
		chain[0].matched   = 1'b0;
		chain[0].any_valid = 1'b0;
	end

	for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
		iapm_cell #(
			.CELL_ID (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	iapm_resolve u_resolve (
		.tok                 (chain[RULE_SLOTS]),
		.reserved_port_limit (reserved_port_limit_q),
		.default_mode        (default_mode_q),
		.res                 (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= wr.en || chain[RULE_SLOTS].active;
			if (chain[0].active) begin
				busy_q <= 1'b1;
			end else if (chain[RULE_SLOTS].active) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			access_mode_q  <= '0;
			rule_matched_q <= 1'b0;
			write_done_q   <= 1'b1;
		end else if (chain[RULE_SLOTS].active) begin
			access_mode_q  <= res.mode;
			rule_matched_q <= res.matched;
			write_done_q   <= 1'b0;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign access_mode  = access_mode_q;
	assign rule_matched = rule_matched_q;
	assign write_done   = write_done_q;

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import iapm_pkg::*;

	localparam int RULE_SLOTS  = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic              en;
		logic [ADDR_W-1:0] net;
		logic [PLEN_W-1:0] plen;
		logic [MODE_W-1:0] rmode;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
	} acl_item_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic              matched;
		logic              wdone;
	} acl_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                operation = 1'b0;
	logic [IDX_W-1:0]    rule_index = '0;
	logic                rule_enable = 1'b0;
	logic [ADDR_W-1:0]   rule_network = '0;
	logic [PLEN_W-1:0]   prefix_length = '0;
	logic [MODE_W-1:0]   rule_mode = '0;
	logic [ADDR_W-1:0]   client_address = '0;
	logic [PORT_W-1:0]   client_port = '0;
	logic                cfg_write = 1'b0;
	logic                cfg_index = 1'b0;
	logic [CFG_W-1:0]    cfg_data = '0;
	wire                 busy;
	wire                 done;
	wire [MODE_W-1:0]    access_mode;
	wire                 rule_matched;
	wire                 write_done;

	logic [ADDR_W-1:0] acl_net [RULE_SLOTS];
	logic [ADDR_W-1:0] acl_mask [RULE_SLOTS];
	logic [MODE_W-1:0] acl_mode [RULE_SLOTS];
	logic              acl_valid [RULE_SLOTS];
	logic [PORT_W-1:0] port_limit;
	logic [MODE_W-1:0] fallback_mode;

	acl_word_t expected_words[$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        sender_idle_pct = 0;

	ipv4_acl_prefix_match #(.RULE_SLOTS(RULE_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.rule_index(rule_index),
		.rule_enable(rule_enable),
		.rule_network(rule_network),
		.prefix_length(prefix_length),
		.rule_mode(rule_mode),
		.client_address(client_address),
		.client_port(client_port),
		.done(done),
		.access_mode(access_mode),
		.rule_matched(rule_matched),
		.write_done(write_done),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[ipv4_acl_prefix_match] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= 40)
			$display("mismatch at cycle %0d: %s got %0h, expected %0h",
				cycle_count, what, got, want);
	endtask

	always @(posedge clk) begin
		acl_word_t w;
		if (done) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", {25'd0, access_mode}, 32'd0);
			end else begin
				w = expected_words.pop_front();
				if (access_mode !== w.mode)
					report_mismatch("access_mode", {25'd0, access_mode}, {25'd0, w.mode});
				if (rule_matched !== w.matched)
					report_mismatch("rule_matched", {31'd0, rule_matched}, {31'd0, w.matched});
				if (write_done !== w.wdone)
					report_mismatch("write_done", {31'd0, write_done}, {31'd0, w.wdone});
			end
		end
	end

	function automatic logic [ADDR_W-1:0] mask_of_prefix(input logic [PLEN_W-1:0] len);
		if (len == 0)
			return '0;
		if (len >= 32)
			return '1;
		return ~32'd0 << (32 - len);
	endfunction

	task automatic clear_acl_model();
		for (int i = 0; i < RULE_SLOTS; i++) begin
			acl_net[i] = '0;
			acl_mask[i] = '0;
			acl_mode[i] = '0;
			acl_valid[i] = 1'b0;
		end
		port_limit = RESERVED_PORT_LIMIT_RESET;
		fallback_mode = DEFAULT_MODE_RESET;
	endtask

	// Updates the rule table copy and queues the word this item must produce.
	task automatic predict_access(input acl_item_t it);
		acl_word_t         w;
		logic              any;
		logic              hit;
		logic [MODE_W-1:0] m;
		logic [ADDR_W-1:0] msk;
		if (it.op == OP_WRITE) begin
			if (it.idx < RULE_SLOTS) begin
				msk = mask_of_prefix(it.plen);
				acl_mask[it.idx] = it.en ? msk : '0;
				acl_net[it.idx] = it.en ? (it.net & msk) : '0;
				acl_mode[it.idx] = it.en ? it.rmode : '0;
				acl_valid[it.idx] = it.en;
			end
			w.mode = '0;
			w.matched = 1'b0;
			w.wdone = 1'b1;
		end else begin
			any = 1'b0;
			hit = 1'b0;
			m = '0;
			for (int i = 0; i < RULE_SLOTS; i++) begin
				if (acl_valid[i]) begin
					any = 1'b1;
					if ((it.addr & acl_mask[i]) == acl_net[i]) begin
						m = acl_mode[i];
						hit = 1'b1;
					end
				end
			end
			if (!any) begin
				m = fallback_mode;
			end else begin
				if ((m & MODE_HOST_SECURE) != 0)
					m = m | MODE_HOST;
				if ((m & MODE_HOST_SECURE) != 0 && it.port >= port_limit) begin
					if ((m & ~(MODE_HOST_SECURE | MODE_HOST)) != 0)
						m = m & ~(MODE_HOST_SECURE | MODE_HOST);
					else
						m = '0;
				end
			end
			w.mode = m;
			w.matched = hit;
			w.wdone = 1'b0;
		end
		expected_words.push_back(w);
	endtask

	task automatic send_item(input acl_item_t it);
		int gap;
		if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= it.op;
		rule_index <= it.idx;
		rule_enable <= it.en;
		rule_network <= it.net;
		prefix_length <= it.plen;
		rule_mode <= it.rmode;
		client_address <= it.addr;
		client_port <= it.port;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_access(it);
	endtask

	function automatic acl_item_t make_item(input logic op);
		acl_item_t it;
		it.op = op;
		it.idx = IDX_W'($urandom);
		it.en = 1'($urandom);
		it.net = $urandom;
		it.plen = PLEN_W'($urandom);
		it.rmode = MODE_W'($urandom);
		it.addr = $urandom;
		it.port = PORT_W'($urandom);
		return it;
	endfunction

	task automatic send_rule(input int idx, input logic en, input logic [ADDR_W-1:0] net,
			input logic [PLEN_W-1:0] plen, input logic [MODE_W-1:0] mode);
		acl_item_t it;
		it = make_item(OP_WRITE);
		it.idx = IDX_W'(idx);
		it.en = en;
		it.net = net;
		it.plen = plen;
		it.rmode = mode;
		send_item(it);
	endtask

	task automatic send_check(input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port);
		acl_item_t it;
		it = make_item(OP_CHECK);
		it.addr = addr;
		it.port = port;
		send_item(it);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (RULE_SLOTS + 4) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (idx == CFG_RESERVED_PORT_LIMIT)
			port_limit = data;
		else
			fallback_mode = data[MODE_W-1:0];
	endtask

	task automatic clear_table();
		for (int i = 0; i < RULE_SLOTS; i++)
			send_rule(i, 1'b0, $urandom, PLEN_W'($urandom), MODE_W'($urandom));
		send_check($urandom, PORT_W'($urandom));
	endtask

	task automatic test_directed_rules();
		send_check(32'h0000_0000, 16'h0000);
		send_check(32'hffff_ffff, 16'hffff);
		send_rule(0, 1'b1, 32'hffff_ffff, 6'd0, 7'h7f);
		send_check(32'h1234_5678, 16'd1023);
		send_check(32'h1234_5678, 16'd1024);
		send_rule(15, 1'b1, 32'hc0a8_0001, 6'd32, MODE_HOST_SECURE);
		send_check(32'hc0a8_0001, 16'd1024);
		send_check(32'hc0a8_0001, 16'd0);
		send_check(32'hc0a8_0002, 16'd0);
		send_rule(7, 1'b1, 32'h0a00_0001, 6'd63, 7'h01);
		send_check(32'h0a00_0001, 16'hffff);
		send_rule(9, 1'b1, 32'h8000_0000, 6'd1, 7'h20);
		send_check(32'h8000_0000, 16'd5);
		send_check(32'h7fff_ffff, 16'd0);
		send_rule(0, 1'b0, 32'hffff_ffff, 6'd0, 7'h7f);
		send_check(32'h7fff_ffff, 16'd0);
		send_rule(3, 1'b1, 32'h0aff_0000, 6'd8, 7'h00);
		send_check(32'h0a12_3456, 16'd80);
		send_rule(15, 1'b0, '0, '0, '0);
		send_rule(9, 1'b0, '0, '0, '0);
		send_rule(7, 1'b0, '0, '0, '0);
		send_rule(3, 1'b0, '0, '0, '0);
		send_check(32'h0a12_3456, 16'd80);
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		int k;
		int r;
		k = $urandom_range(0, RULE_SLOTS - 1);
		r = $urandom_range(0, 99);
		if (r < 55)
			return acl_net[k] | ($urandom & ~acl_mask[k]);
		if (r < 65)
			return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hffff_ffff;
		return $urandom;
	endfunction

	function automatic logic [PORT_W-1:0] pick_port();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return port_limit + PORT_W'($urandom_range(0, 2)) - PORT_W'(1);
		if (r < 50)
			return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
		return PORT_W'($urandom);
	endfunction

	task automatic test_random_traffic(input int count);
		acl_item_t it;
		int        k;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				clear_table();
			if ($urandom_range(0, 99) < 35) begin
				it = make_item(OP_WRITE);
				it.en = ($urandom_range(0, 99) < 80);
				if ($urandom_range(0, 99) < 85)
					it.plen = PLEN_W'($urandom_range(0, 32));
				else
					it.plen = PLEN_W'($urandom_range(33, 63));
				if ($urandom_range(0, 99) < 30) begin
					k = $urandom_range(0, RULE_SLOTS - 1);
					it.net = acl_net[k] | ($urandom & ~acl_mask[k]);
				end
			end else begin
				it = make_item(OP_CHECK);
				it.addr = pick_address();
				it.port = pick_port();
			end
			send_item(it);
		end
	endtask

	task automatic test_config_phase(input logic [CFG_W-1:0] limit,
			input logic [CFG_W-1:0] dmode, input int idle_pct, input int count);
		drain();
		write_register(CFG_RESERVED_PORT_LIMIT, limit);
		write_register(CFG_DEFAULT_MODE, dmode);
		sender_idle_pct = idle_pct;
		clear_table();
		test_random_traffic(count);
	endtask

	initial begin
		clear_acl_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_rules();
		test_config_phase(16'h0000, 16'hff80, 26, 510);
		test_config_phase(16'hffff, 16'h007f, 55, 510);
		test_config_phase(CFG_W'($urandom), CFG_W'($urandom), 0, 510);
		drain();
		if (error_count == 0)
			$display("[ipv4_acl_prefix_match] OK");
		else
			$display("[ipv4_acl_prefix_match] ERROR");
		$finish;
	end

endmodule
